FILE: hdl/utf8sd_pkg.sv
// Package for the UTF-8 stream decoder: widths, lead-byte table and helpers.
// Used by utf8_stream_decoder; depends on nothing else.

package utf8sd_pkg;

   localparam int BYTE_WIDTH  = 8;
   localparam int CP_WIDTH    = 31;
   localparam int COUNT_WIDTH = 16;
   localparam int LEFT_WIDTH  = 3;
   localparam int MAX_LEN     = 6;
   localparam int LEN_WIDTH   = 3;
   localparam int CONT_BITS   = 6;
   localparam int RSP_DATA_WIDTH = ((CP_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

   typedef logic [BYTE_WIDTH-1:0]  byte_type;
   typedef logic [CP_WIDTH-1:0]    code_point_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [LEFT_WIDTH-1:0]  left_type;
   typedef logic [LEN_WIDTH-1:0]   len_type;

   localparam logic [CONT_BITS-1:0] CONT_MASK = 6'h3F;
   localparam count_type COUNT_LIMIT = '1;

   // Mask applied to a lead byte, indexed by sequence length minus one.
   localparam byte_type LEAD_MASK [MAX_LEN] = '{
      8'h7F, 8'h1F, 8'h0F, 8'h07, 8'h03, 8'h01
   };

   // Sequence length from the legacy six-byte lead table. Stray continuation
   // bytes and 0xFE/0xFF count as single-byte characters.
   function automatic len_type lead_length(input byte_type b);
      len_type len;
      case (b) inside
         [8'hC0:8'hDF]: len = 3'd2;
         [8'hE0:8'hEF]: len = 3'd3;
         [8'hF0:8'hF7]: len = 3'd4;
         [8'hF8:8'hFB]: len = 3'd5;
         [8'hFC:8'hFD]: len = 3'd6;
         default:       len = 3'd1;
      endcase
      return len;
   endfunction

endpackage

FILE: hdl/utf8_stream_decoder.sv
// UTF-8 stream decoder with the legacy six-byte lead table, one byte per transaction.
// Depends on utf8sd_pkg.
//
//   channel | ports   | tdata / tuser                               | role
//   --------+---------+---------------------------------------------+-------------------
//   input   | req_*   | tdata[7:0] text_byte                        | one raw string byte
//   result  | rsp_*   | tdata[30:0] code_point, [46:31] char_count, | decoded character
//           |         | [47] zero; tuser[0] is_end                  | or end of string
//
// Each byte is decoded as it is accepted: the decoder state updates at the accepting
// edge and a result, if the byte completes one, sits in the result register
// from the next cycle on. A byte is taken every cycle while the result register
// is empty or being drained. Synchronous reset clears the decoder state and
// the result valid flag; a result held under backpressure stalls the input.

module utf8_stream_decoder
   import utf8sd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [BYTE_WIDTH-1:0]     req_tdata,   // [7:0] text_byte
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // [30:0] code_point, [46:31] char_count
   output logic                      rsp_tuser    // [0] is_end
);

   left_type       bytes_left_ff, bytes_left_in;
   code_point_type partial_ff, partial_in;
   count_type      chars_ff, chars_in;

   logic           rsp_valid_ff, rsp_valid_in;
   code_point_type rsp_cp_ff, rsp_cp_in;
   count_type      rsp_count_ff, rsp_count_in;
   logic           rsp_end_ff, rsp_end_in;

   logic           accept;
   logic           emit;
   byte_type       text_byte;
   len_type        len;
   count_type      chars_inc;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign text_byte  = req_tdata;
   assign len        = lead_length(text_byte);
   assign chars_inc  = (chars_ff == COUNT_LIMIT) ? chars_ff : chars_ff + 1'b1;

   always_comb begin
      bytes_left_in = bytes_left_ff;
      partial_in    = partial_ff;
      chars_in      = chars_ff;
      emit          = 1'b0;
      rsp_cp_in     = rsp_cp_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_end_in    = rsp_end_ff;

      if (accept) begin
         if (bytes_left_ff != '0) begin
            // Continuation bytes are not checked; a zero byte here is data.
            partial_in    = {partial_ff[CP_WIDTH-CONT_BITS-1:0], text_byte[CONT_BITS-1:0] & CONT_MASK};
            bytes_left_in = bytes_left_ff - 1'b1;
            if (bytes_left_ff == left_type'(1)) begin
               emit         = 1'b1;
               chars_in     = chars_inc;
               rsp_cp_in    = partial_in;
               rsp_count_in = chars_inc;
               rsp_end_in   = 1'b0;
            end
         end else if (text_byte == '0) begin
            emit         = 1'b1;
            rsp_cp_in    = '0;
            rsp_count_in = chars_ff;
            rsp_end_in   = 1'b1;
            chars_in     = '0;
            partial_in   = '0;
         end else begin
            partial_in    = code_point_type'(text_byte & LEAD_MASK[len - 1'b1]);
            bytes_left_in = left_type'(len - 1'b1);
            if (len == len_type'(1)) begin
               emit         = 1'b1;
               chars_in     = chars_inc;
               rsp_cp_in    = partial_in;
               rsp_count_in = chars_inc;
               rsp_end_in   = 1'b0;
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         partial_ff    <= '0;
         chars_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         partial_ff    <= partial_in;
         chars_ff      <= chars_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cp_ff    <= rsp_cp_in;
      rsp_count_ff <= rsp_count_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - CP_WIDTH - COUNT_WIDTH){1'b0}}, rsp_count_ff, rsp_cp_ff};
   assign rsp_tuser  = rsp_end_ff;

endmodule
